// ===== hw/rtl/bpa_pkg.sv =====
// Shared types and constants for the buffer pool allocator.
`default_nettype none

package bpa_pkg;

	localparam int BPA_BUFFER_COUNT = 4;
	localparam int BPA_BUFFER_MAX   = 64;
	localparam int BPA_INDEX_W      = 6;
	localparam int BPA_COUNT_W      = 7;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXHAUSTED = 3'd1,
		ST_DISABLED  = 3'd2,
		ST_WAS_FREE  = 3'd3,
		ST_UNKNOWN   = 3'd4
	} bpa_status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} bpa_req_t;

	// Outcome of the lowest-free-buffer search.
	typedef struct packed {
		logic                   found;
		logic [BPA_INDEX_W-1:0] index;
	} bpa_pick_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpa_pick.sv =====
// Priority encoder that finds the lowest-numbered free buffer.
`default_nettype none

module bpa_pick
	import bpa_pkg::*;
#(
	parameter int BUFFER_COUNT = BPA_BUFFER_COUNT
) (
	input  wire logic [BUFFER_COUNT-1:0] flags,
	output bpa_pick_t                    pick
);

	// Scan from the top down so the lowest free index wins.
	always_comb begin
		pick.found = 1'b0;
		pick.index = '0;
		for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
			if (!flags[i]) begin
				pick.found = 1'b1;
				pick.index = BPA_INDEX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/buffer_pool_allocator_top.sv =====
// Top level of the bitmap buffer pool allocator.
//
// Each request (start high while busy is low) is captured in an input register
// and resolved in the next cycle against the in-use flags; its result is
// captured in the result register and appears on the result ports with
// done high for exactly one cycle. The receiver cannot stall, so busy stays
// low and a new request may be issued every cycle: throughput is one request
// per cycle, set by the single stage between the input register and the
// result register. Allocate grants the lowest free buffer; free clears the
// given flag. Writing pool_enable from 0 to 1 clears every flag, the in-use
// count and the peak; write the register only while no request is in flight.
`default_nettype none

module buffer_pool_allocator_top
	import bpa_pkg::*;
#(
	parameter int BUFFER_COUNT = BPA_BUFFER_COUNT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// request channel
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   req_type,
	input  wire logic [BPA_INDEX_W-1:0] buffer_index,
	// configuration write channel (pool_enable)
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data,
	// result channel
	output logic                        done,
	output logic [2:0]                  status,
	output logic [BPA_INDEX_W-1:0]      granted_index,
	output logic [BPA_COUNT_W-1:0]      total_count,
	output logic [BPA_COUNT_W-1:0]      in_use_count,
	output logic [BPA_COUNT_W-1:0]      peak_count
);

	localparam logic [BPA_COUNT_W-1:0] PoolSize = BPA_COUNT_W'(BUFFER_COUNT);

	// Input register stage.
	logic                   start_s1;
	logic                   req_type_s1;
	logic [BPA_INDEX_W-1:0] buffer_index_s1;

	// Pool state.
	logic                    enable_q;
	logic [BUFFER_COUNT-1:0] flags_q;
	logic [BPA_COUNT_W-1:0]  used_q;
	logic [BPA_COUNT_W-1:0]  peak_q;

	// Result register.
	logic                   done_q;
	logic [2:0]             status_q;
	logic [BPA_INDEX_W-1:0] granted_q;
	logic [BPA_COUNT_W-1:0] total_q;
	logic [BPA_COUNT_W-1:0] used_out_q;
	logic [BPA_COUNT_W-1:0] peak_out_q;

	// Resolve logic.
	bpa_pick_t               pick;
	logic [BUFFER_COUNT-1:0] hit;
	logic                    idx_known;
	logic                    idx_busy;
	logic                    do_grant;
	logic                    do_release;
	logic [BUFFER_COUNT-1:0] flags_d;
	logic [BPA_COUNT_W-1:0]  used_d;
	logic [BPA_COUNT_W-1:0]  peak_d;
	bpa_status_t             status_d;
	logic                    cfg_write;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;

	bpa_pick #(
		.BUFFER_COUNT(BUFFER_COUNT)
	) u_pick (
		.flags(flags_q),
		.pick (pick)
	);

	// Decode the free index to a one-hot select over the pool.
	always_comb begin
		for (int i = 0; i < BUFFER_COUNT; i++) begin
			hit[i] = (buffer_index_s1 == BPA_INDEX_W'(i));
		end
	end

	assign idx_known = ({1'b0, buffer_index_s1} < PoolSize);
	assign idx_busy  = |(flags_q & hit);

	always_comb begin
		do_grant   = 1'b0;
		do_release = 1'b0;
		status_d   = ST_OK;
		if (!enable_q) begin
			status_d = ST_DISABLED;
		end else if (req_type_s1 == REQ_ALLOC) begin
			do_grant = pick.found;
			status_d = pick.found ? ST_OK : ST_EXHAUSTED;
		end else if (!idx_known) begin
			status_d = ST_UNKNOWN;
		end else begin
			do_release = idx_busy;
			status_d   = idx_busy ? ST_OK : ST_WAS_FREE;
		end
	end

	// Next flags and counters; the count tracks the flags incrementally.
	always_comb begin
		flags_d = flags_q;
		used_d  = used_q;
		peak_d  = peak_q;
		if (do_grant) begin
			for (int i = 0; i < BUFFER_COUNT; i++) begin
				if (pick.index == BPA_INDEX_W'(i)) begin
					flags_d[i] = 1'b1;
				end
			end
			used_d = used_q + BPA_COUNT_W'(1);
			if (used_d > peak_q) begin
				peak_d = used_d;
			end
		end else if (do_release) begin
			flags_d = flags_q & ~hit;
			used_d  = used_q - BPA_COUNT_W'(1);
		end
	end

	// Capture the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_type_s1     <= req_type;
			buffer_index_s1 <= buffer_index;
		end
	end

	// Pool state: enable on a rising write clears the pool, requests update it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			flags_q  <= '0;
			used_q   <= '0;
			peak_q   <= '0;
		end else if (cfg_write) begin
			enable_q <= cfg_data;
			if (cfg_data && !enable_q) begin
				flags_q <= '0;
				used_q  <= '0;
				peak_q  <= '0;
			end
		end else if (start_s1) begin
			flags_q <= flags_d;
			used_q  <= used_d;
			peak_q  <= peak_d;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start_s1;
		end
	end

	// Result payload; while disabled every count reads as zero.
	always_ff @(posedge clk) begin
		if (start_s1) begin
			status_q   <= status_d;
			granted_q  <= do_grant ? pick.index : '0;
			total_q    <= enable_q ? PoolSize : '0;
			used_out_q <= enable_q ? used_d : '0;
			peak_out_q <= enable_q ? peak_d : '0;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign total_count   = total_q;
	assign in_use_count  = used_out_q;
	assign peak_count    = peak_out_q;

endmodule

`default_nettype wire
